@@ rtl/escaped_frame_receiver_macros.svh @@
// Assertion macros for the escaped frame receiver checker.
`ifndef ESCAPED_FRAME_RECEIVER_MACROS_SVH
`define ESCAPED_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off in reset.
`define EFR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("escaped_frame_receiver check failed");

// Next-cycle implication.
`define EFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("escaped_frame_receiver check failed");

`endif

@@ rtl/efr_pkg.sv @@
// Package: codes, widths and shared types of the escaped frame receiver.
package efr_pkg;

  localparam int DEF_FRAME_BYTES = 32;
  localparam int LEN_W           = 6;
  localparam int IDX_W           = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 8;
  localparam int NUM_ENTRIES     = 3;

  localparam logic [7:0] HEAD_CODE = 8'hFD;
  localparam logic [7:0] ESC_CODE  = 8'hFE;
  localparam logic [7:0] TAIL_CODE = 8'hF8;
  localparam logic [7:0] ESC_HEAD  = 8'h7D;
  localparam logic [7:0] ESC_TAIL  = 8'h78;
  localparam logic [7:0] ESC_ESC   = 8'h7E;

  localparam logic [CFG_IDX_W-1:0] REG_TYPE_A  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_A   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_B  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_B   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TYPE_C  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEN_C   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_EN  = 3'd6;

  typedef struct packed {
    logic       hit;
    logic [1:0] entry;
  } match_t;

  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] r;
    case (b)
      ESC_HEAD: r = HEAD_CODE;
      ESC_TAIL: r = TAIL_CODE;
      ESC_ESC:  r = ESC_CODE;
      default:  r = b;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/escaped_frame_receiver.sv @@
// Escaped frame receiver: unstuffs bytes into a frame store and replays matched frames.
// Steps: a byte is taken while receiving; a closing tail starts a scan of the n stored bytes
// (a read, then an accumulate step each), a decision step, then a read and an output write per emitted byte.
// Throughput: one byte per cycle between frames; no byte is taken while a frame closes.
// Reset clears control state and configuration; the frame memory is not cleared.
module escaped_frame_receiver
  import efr_pkg::*;
#(
  parameter int FRAME_BYTES = DEF_FRAME_BYTES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            rx_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            frame_byte_o,
  output logic [IDX_W-1:0]      byte_index_o,
  output logic [1:0]            entry_hit_o,
  output logic                  status_o,
  output logic                  last_o
);

  localparam int ADDR_W = $clog2(FRAME_BYTES);
  localparam int FILL_W = $clog2(FRAME_BYTES + 1);
  localparam int EXT_W  = IDX_W + ADDR_W;

  localparam logic [2:0] S_RX       = 3'd0;
  localparam logic [2:0] S_SCAN_RD  = 3'd1;
  localparam logic [2:0] S_SCAN_ACC = 3'd2;
  localparam logic [2:0] S_DEC      = 3'd3;
  localparam logic [2:0] S_EMIT_RD  = 3'd4;
  localparam logic [2:0] S_EMIT_WR  = 3'd5;

  logic [2:0]        state_q, state_d;
  logic              in_frame_q, in_frame_d;
  logic              esc_q, esc_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [FILL_W-1:0] len_q, len_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [7:0]        sum_q, sum_d;
  logic [7:0]        chk_q, chk_d;
  logic [7:0]        type_q, type_d;
  logic [1:0]        entry_q, entry_d;

  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  logic [1:0]        out_entry_q, out_entry_d;
  logic              out_status_q, out_status_d;
  logic              out_last_q, out_last_d;
  logic              out_load;
  logic              out_free;

  logic              in_accept;
  logic              head;
  logic              live;
  logic              esc_eff;
  logic [FILL_W-1:0] fill_eff;
  logic [7:0]        store_byte;

  logic              wr_en;
  logic              rd_en;
  logic [7:0]        rd_data;
  logic              sum_en;
  match_t            match;

  logic [FILL_W-1:0] ptr_w;
  logic [EXT_W-1:0]  ptr_ext;
  logic              ptr_last;

  efr_store #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (fill_eff[ADDR_W-1:0]),
    .wr_data_i (store_byte),
    .rd_en_i   (rd_en),
    .rd_addr_i (ptr_q),
    .rd_data_o (rd_data)
  );

  efr_cfg #(
    .FILL_W (FILL_W)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .type_byte_i (type_q),
    .frame_len_i (len_q),
    .sum_en_o    (sum_en),
    .match_o     (match)
  );

  assign in_stall_o = (state_q != S_RX);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // a head byte reopens the frame from scratch
  assign head       = (rx_byte_i == HEAD_CODE);
  assign live       = head || in_frame_q;
  assign esc_eff    = head ? 1'b0 : esc_q;
  assign fill_eff   = head ? '0 : fill_q;
  assign store_byte = esc_eff ? unescape(rx_byte_i) : rx_byte_i;

  assign ptr_w    = FILL_W'(ptr_q);
  assign ptr_ext  = EXT_W'(ptr_q);
  assign ptr_last = (ptr_w + FILL_W'(1)) == len_q;

  always_comb begin
    state_d      = state_q;
    in_frame_d   = in_frame_q;
    esc_d        = esc_q;
    fill_d       = fill_q;
    len_d        = len_q;
    ptr_d        = ptr_q;
    sum_d        = sum_q;
    chk_d        = chk_q;
    type_d       = type_q;
    entry_d      = entry_q;
    wr_en        = 1'b0;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    out_byte_d   = out_byte_q;
    out_idx_d    = out_idx_q;
    out_entry_d  = out_entry_q;
    out_status_d = out_status_q;
    out_last_d   = out_last_q;

    case (state_q)
      S_RX: begin
        if (in_accept && live) begin
          if (!esc_eff && rx_byte_i == ESC_CODE) begin
            in_frame_d = 1'b1;
            esc_d      = 1'b1;
            fill_d     = fill_eff;
          end else if (fill_eff >= FILL_W'(FRAME_BYTES)) begin
            in_frame_d = 1'b0;
            esc_d      = 1'b0;
            fill_d     = '0;
          end else begin
            wr_en      = 1'b1;
            esc_d      = 1'b0;
            if (!esc_eff && rx_byte_i == TAIL_CODE) begin
              in_frame_d = 1'b0;
              fill_d     = '0;
              len_d      = fill_eff + FILL_W'(1);
              ptr_d      = '0;
              sum_d      = '0;
              state_d    = S_SCAN_RD;
            end else begin
              in_frame_d = 1'b1;
              fill_d     = fill_eff + FILL_W'(1);
            end
          end
        end
      end
      S_SCAN_RD: begin
        rd_en   = 1'b1;
        state_d = S_SCAN_ACC;
      end
      S_SCAN_ACC: begin
        if (ptr_q == ADDR_W'(1)) begin
          type_d = rd_data;
        end
        if ((ptr_w + FILL_W'(2)) == len_q) begin
          chk_d = rd_data;
        end
        if (ptr_q != '0 && (ptr_w + FILL_W'(2)) < len_q) begin
          sum_d = sum_q + rd_data;
        end
        if (ptr_last) begin
          state_d = S_DEC;
        end else begin
          ptr_d   = ptr_q + ADDR_W'(1);
          state_d = S_SCAN_RD;
        end
      end
      S_DEC: begin
        if (match.hit && (!sum_en || sum_q == chk_q)) begin
          entry_d = match.entry;
          ptr_d   = '0;
          state_d = S_EMIT_RD;
        end else if (out_free) begin
          out_load     = 1'b1;
          out_byte_d   = '0;
          out_idx_d    = '0;
          out_entry_d  = '0;
          out_status_d = 1'b1;
          out_last_d   = 1'b1;
          state_d      = S_RX;
        end
      end
      S_EMIT_RD: begin
        rd_en   = 1'b1;
        state_d = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_byte_d   = rd_data;
          out_idx_d    = ptr_ext[IDX_W-1:0];
          out_entry_d  = entry_q;
          out_status_d = 1'b0;
          out_last_d   = ptr_last;
          if (ptr_last) begin
            state_d = S_RX;
          end else begin
            ptr_d   = ptr_q + ADDR_W'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_RX;
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RX;
      in_frame_q  <= 1'b0;
      esc_q       <= 1'b0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_frame_q  <= in_frame_d;
      esc_q       <= esc_d;
      fill_q      <= fill_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    ptr_q   <= ptr_d;
    sum_q   <= sum_d;
    chk_q   <= chk_d;
    type_q  <= type_d;
    entry_q <= entry_d;
    if (out_load) begin
      out_byte_q   <= out_byte_d;
      out_idx_q    <= out_idx_d;
      out_entry_q  <= out_entry_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign frame_byte_o = out_byte_q;
  assign byte_index_o = out_idx_q;
  assign entry_hit_o  = out_entry_q;
  assign status_o     = out_status_q;
  assign last_o       = out_last_q;

endmodule

@@ rtl/efr_store.sv @@
// Frame byte memory: one write port, one registered read port.
module efr_store #(
  parameter int FRAME_BYTES = 32,
  localparam int ADDR_W = $clog2(FRAME_BYTES)
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [7:0]        wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [7:0]        rd_data_o
);

  logic [7:0] mem [FRAME_BYTES];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ rtl/efr_cfg.sv @@
// Configuration registers and the frame type/length entry match.
module efr_cfg
  import efr_pkg::*;
#(
  parameter int FILL_W = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [7:0]            type_byte_i,
  input  logic [FILL_W-1:0]     frame_len_i,
  output logic                  sum_en_o,
  output match_t                match_o
);

  localparam int CMP_W = (FILL_W > LEN_W) ? FILL_W : LEN_W;

  logic [7:0]       type_q [NUM_ENTRIES];
  logic [LEN_W-1:0] len_q  [NUM_ENTRIES];
  logic             sum_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_ENTRIES; i++) begin
        type_q[i] <= '0;
        len_q[i]  <= '0;
      end
      sum_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TYPE_A: type_q[0] <= cfg_data_i[7:0];
        REG_LEN_A:  len_q[0]  <= cfg_data_i[LEN_W-1:0];
        REG_TYPE_B: type_q[1] <= cfg_data_i[7:0];
        REG_LEN_B:  len_q[1]  <= cfg_data_i[LEN_W-1:0];
        REG_TYPE_C: type_q[2] <= cfg_data_i[7:0];
        REG_LEN_C:  len_q[2]  <= cfg_data_i[LEN_W-1:0];
        REG_SUM_EN: sum_en_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // later entries override earlier ones
  always_comb begin
    match_o = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      if (type_byte_i == type_q[i] && CMP_W'(frame_len_i) == CMP_W'(len_q[i])) begin
        match_o.hit   = 1'b1;
        match_o.entry = 2'(i);
      end
    end
  end

  assign sum_en_o = sum_en_q;

endmodule

@@ rtl/efr_checker.sv @@
// Port checker for the escaped frame receiver, bound to the top level.
`include "escaped_frame_receiver_macros.svh"

module efr_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] frame_byte_o,
  input logic [4:0] byte_index_o,
  input logic [1:0] entry_hit_o,
  input logic       status_o,
  input logic       last_o
);

  `EFR_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `EFR_ASSERT_IMPL(a_reject_form, out_valid_o && status_o,
                   last_o && frame_byte_o == 8'd0 && byte_index_o == 5'd0 && entry_hit_o == 2'd0)
  `EFR_ASSERT_IMPL(a_entry_range, out_valid_o, entry_hit_o != 2'd3)
  `EFR_ASSERT_IMPL(a_busy_mid_frame, out_valid_o && !last_o, in_stall_o)

endmodule

bind escaped_frame_receiver efr_checker u_efr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .frame_byte_o (frame_byte_o),
  .byte_index_o (byte_index_o),
  .entry_hit_o  (entry_hit_o),
  .status_o     (status_o),
  .last_o       (last_o)
);

@@ verif/escaped_frame_receiver_tb.sv @@
// Self-checking testbench for the escaped frame receiver: directed rows, then random frames.
module escaped_frame_receiver_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import efr_pkg::*;

  localparam int FRAME_BYTES   = DEF_FRAME_BYTES;
  localparam int SETTLE_CYCLES = 2 * FRAME_BYTES + 8;
  localparam int CYCLE_LIMIT   = 200000;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic ST_ACCEPT = 1'b0;
  localparam logic ST_REJECT = 1'b1;

  typedef struct packed {
    logic [7:0]       frame_byte;
    logic [IDX_W-1:0] byte_index;
    logic [1:0]       entry_hit;
    logic             status;
    logic             last;
  } frame_res_t;

  localparam frame_res_t REJECT_RESULT = '{
    frame_byte: 8'h00, byte_index: '0, entry_hit: 2'd0, status: ST_REJECT, last: 1'b1
  };

  typedef enum logic [1:0] {ROW_BYTE, ROW_REJECT, ROW_REG} row_op_e;

  typedef struct packed {
    row_op_e              op;
    logic [CFG_IDX_W-1:0] idx;
    logic [7:0]           val;
  } dir_row_t;

  typedef enum {FK_GOOD, FK_MISS, FK_BROKEN, FK_NOISE, FK_MAX, FK_OVERFLOW} frame_kind_e;

  localparam int DIR_N = 37;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_BYTE,   '0,          8'h11},
    '{ROW_BYTE,   '0,          TAIL_CODE},
    '{ROW_BYTE,   '0,          HEAD_CODE},
    '{ROW_REJECT, '0,          TAIL_CODE},
    '{ROW_REG,    REG_TYPE_A,  TAIL_CODE},
    '{ROW_REG,    REG_LEN_A,   8'd2},
    '{ROW_REG,    REG_TYPE_B,  8'h00},
    '{ROW_REG,    REG_LEN_B,   8'd8},
    '{ROW_REG,    REG_TYPE_C,  8'h00},
    '{ROW_REG,    REG_LEN_C,   8'hC8},
    '{ROW_REG,    REG_SUM_EN,  8'hFE},
    '{ROW_REG,    REG_UNUSED,  8'hFF},
    '{ROW_BYTE,   '0,          HEAD_CODE},
    '{ROW_BYTE,   '0,          TAIL_CODE},
    '{ROW_BYTE,   '0,          HEAD_CODE},
    '{ROW_BYTE,   '0,          8'h00},
    '{ROW_BYTE,   '0,          ESC_CODE},
    '{ROW_BYTE,   '0,          ESC_HEAD},
    '{ROW_BYTE,   '0,          ESC_CODE},
    '{ROW_BYTE,   '0,          ESC_TAIL},
    '{ROW_BYTE,   '0,          ESC_CODE},
    '{ROW_BYTE,   '0,          ESC_ESC},
    '{ROW_BYTE,   '0,          ESC_CODE},
    '{ROW_BYTE,   '0,          TAIL_CODE},
    '{ROW_BYTE,   '0,          ESC_CODE},
    '{ROW_BYTE,   '0,          ESC_CODE},
    '{ROW_BYTE,   '0,          TAIL_CODE},
    '{ROW_BYTE,   '0,          HEAD_CODE},
    '{ROW_BYTE,   '0,          ESC_CODE},
    '{ROW_BYTE,   '0,          HEAD_CODE},
    '{ROW_BYTE,   '0,          8'h00},
    '{ROW_REJECT, '0,          TAIL_CODE},
    '{ROW_REG,    REG_TYPE_B,  8'hFF},
    '{ROW_REG,    REG_LEN_B,   8'd3},
    '{ROW_BYTE,   '0,          HEAD_CODE},
    '{ROW_BYTE,   '0,          8'hFF},
    '{ROW_BYTE,   '0,          TAIL_CODE}
  };

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            rx_byte_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            frame_byte_o;
  logic [IDX_W-1:0]      byte_index_o;
  logic [1:0]            entry_hit_o;
  logic                  status_o;
  logic                  last_o;

  escaped_frame_receiver dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .frame_byte_o (frame_byte_o),
    .byte_index_o (byte_index_o),
    .entry_hit_o  (entry_hit_o),
    .status_o     (status_o),
    .last_o       (last_o)
  );

  // shadow of the deframer state and its configuration
  logic [7:0]       shadow_store [FRAME_BYTES];
  int               shadow_fill = 0;
  logic             shadow_open = 1'b0;
  logic             shadow_esc  = 1'b0;
  logic [7:0]       acc_type [NUM_ENTRIES] = '{default: '0};
  logic [LEN_W-1:0] acc_len  [NUM_ENTRIES] = '{default: '0};
  logic             acc_sum_en = 1'b0;

  frame_res_t owed_results [$];
  frame_res_t fresh_results [$];
  logic [7:0] frame_raw [$];

  int   mismatches   = 0;
  int   results_seen = 0;
  int   bytes_sent   = 0;
  int   cycle_count  = 0;
  int   stall_left   = 0;
  logic gaps_on      = 1'b1;
  logic stalls_on    = 1'b1;
  logic gap_calm     = 1'b0;
  logic stall_calm   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (stalls_on && !stall_calm && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 2);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
    if ($urandom_range(0, 99) == 0) stall_calm <= ~stall_calm;
  end

  always @(posedge clk_i) begin
    frame_res_t got;
    frame_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{frame_byte_o, byte_index_o, entry_hit_o, status_o, last_o};
      results_seen++;
      if (owed_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d unexpected: %h/%0d/%0d/%b/%b", results_seen,
                   got.frame_byte, got.byte_index, got.entry_hit, got.status, got.last);
      end else begin
        want = owed_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d: want %h/%0d/%0d/%b/%b got %h/%0d/%0d/%b/%b", results_seen,
                     want.frame_byte, want.byte_index, want.entry_hit, want.status, want.last,
                     got.frame_byte, got.byte_index, got.entry_hit, got.status, got.last);
        end
      end
    end
  end

  task automatic unstuff_byte(input logic [7:0] raw);
    logic [7:0] b;
    logic [7:0] sum;
    logic       closes;
    logic       sum_ok;
    int         n;
    int         hit;
    b      = raw;
    closes = 1'b0;
    if (b == HEAD_CODE) begin
      shadow_fill = 0;
      shadow_open = 1'b1;
      shadow_esc  = 1'b0;
    end else if (!shadow_open) begin
      return;
    end
    if (shadow_esc) begin
      shadow_esc = 1'b0;
      case (b)
        ESC_HEAD: b = HEAD_CODE;
        ESC_TAIL: b = TAIL_CODE;
        ESC_ESC:  b = ESC_CODE;
        default:  b = b;
      endcase
    end else if (b == ESC_CODE) begin
      shadow_esc = 1'b1;
      return;
    end else if (b == TAIL_CODE) begin
      closes = 1'b1;
    end
    if (shadow_fill >= FRAME_BYTES) begin
      shadow_fill = 0;
      shadow_open = 1'b0;
      return;
    end
    shadow_store[shadow_fill] = b;
    shadow_fill++;
    if (!closes) return;

    n      = shadow_fill;
    hit    = -1;
    sum_ok = 1'b1;
    if (acc_sum_en) begin
      sum = 8'h00;
      for (int i = 1; i + 2 < n; i++) sum = sum + shadow_store[i];
      if (sum != shadow_store[n-2]) sum_ok = 1'b0;
    end
    if (sum_ok)
      for (int e = 0; e < NUM_ENTRIES; e++)
        if (shadow_store[1] == acc_type[e] && n == int'(acc_len[e])) hit = e;
    shadow_fill = 0;
    shadow_open = 1'b0;
    if (hit < 0) begin
      fresh_results.push_back(REJECT_RESULT);
    end else begin
      for (int i = 0; i < n; i++)
        fresh_results.push_back('{shadow_store[i], IDX_W'(i), 2'(hit), ST_ACCEPT, i + 1 == n});
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    case (idx)
      REG_TYPE_A: acc_type[0] = val;
      REG_LEN_A:  acc_len[0]  = val[LEN_W-1:0];
      REG_TYPE_B: acc_type[1] = val;
      REG_LEN_B:  acc_len[1]  = val[LEN_W-1:0];
      REG_TYPE_C: acc_type[2] = val;
      REG_LEN_C:  acc_len[2]  = val[LEN_W-1:0];
      REG_SUM_EN: acc_sum_en  = val[0];
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic reject_typed);
    if (gaps_on && !gap_calm && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    bytes_sent++;
    fresh_results.delete();
    unstuff_byte(b);
    if (reject_typed) owed_results.push_back(REJECT_RESULT);
    else foreach (fresh_results[i]) owed_results.push_back(fresh_results[i]);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic program_entries(input logic [7:0] t0, l0, t1, l1, t2, l2, sum_en);
    settle();
    write_reg(REG_TYPE_A, t0);
    write_reg(REG_LEN_A, l0);
    write_reg(REG_TYPE_B, t1);
    write_reg(REG_LEN_B, l1);
    write_reg(REG_TYPE_C, t2);
    write_reg(REG_LEN_C, l2);
    write_reg(REG_SUM_EN, sum_en);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(0, 23))
      0:       v = HEAD_CODE;
      1:       v = ESC_CODE;
      2:       v = TAIL_CODE;
      3:       v = ESC_HEAD;
      4:       v = ESC_TAIL;
      5:       v = ESC_ESC;
      default: v = 8'($urandom_range(0, 255));
    endcase
    return v;
  endfunction

  task automatic build_frame(input frame_kind_e kind);
    logic [7:0] d [FRAME_BYTES];
    logic [7:0] sum;
    int         n;
    int         e;
    int         cut;
    frame_raw.delete();
    e = $urandom_range(0, NUM_ENTRIES - 1);
    n = acc_len[e];
    case (kind)
      FK_NOISE: begin
        repeat ($urandom_range(1, 6)) frame_raw.push_back(pick_byte());
        return;
      end
      FK_OVERFLOW: begin
        frame_raw.push_back(HEAD_CODE);
        repeat ($urandom_range(FRAME_BYTES, FRAME_BYTES + 4))
          frame_raw.push_back(8'($urandom_range(0, 127)));
        frame_raw.push_back(TAIL_CODE);
        return;
      end
      FK_MAX: begin
        n = FRAME_BYTES;
        for (int i = 0; i < NUM_ENTRIES; i++) if (acc_len[i] == FRAME_BYTES) e = i;
      end
      FK_MISS: n = $urandom_range(2, 10);
      default: if (n < 2 || n > 12) n = $urandom_range(2, 8);
    endcase

    d[0]   = HEAD_CODE;
    d[n-1] = TAIL_CODE;
    for (int i = 1; i < n - 1; i++) d[i] = pick_byte();
    if (kind != FK_MISS && n >= 3 && $urandom_range(0, 9) != 0) d[1] = acc_type[e];
    if (acc_sum_en && n >= 3 && $urandom_range(0, 4) != 0) begin
      sum = 8'h00;
      for (int i = 1; i + 2 < n; i++) sum = sum + d[i];
      d[n-2] = sum;
    end

    frame_raw.push_back(HEAD_CODE);
    for (int i = 1; i < n - 1; i++) begin
      if (d[i] == HEAD_CODE) begin
        frame_raw.push_back(ESC_CODE);
        frame_raw.push_back(ESC_HEAD);
      end else if (d[i] == ESC_CODE || d[i] == TAIL_CODE) begin
        frame_raw.push_back(ESC_CODE);
        if ($urandom_range(0, 1) == 0) frame_raw.push_back(d[i]);
        else frame_raw.push_back(d[i] == ESC_CODE ? ESC_ESC : ESC_TAIL);
      end else if (d[i] != ESC_HEAD && d[i] != ESC_TAIL && d[i] != ESC_ESC &&
                   $urandom_range(0, 7) == 0) begin
        frame_raw.push_back(ESC_CODE);
        frame_raw.push_back(d[i]);
      end else begin
        frame_raw.push_back(d[i]);
      end
    end
    frame_raw.push_back(TAIL_CODE);

    if (kind == FK_BROKEN) begin
      cut = $urandom_range(1, frame_raw.size() - 1);
      while (frame_raw.size() > cut) void'(frame_raw.pop_back());
      if ($urandom_range(0, 1) == 0) frame_raw.push_back(ESC_CODE);
    end
  endtask

  task automatic send_frame(input frame_kind_e kind);
    build_frame(kind);
    foreach (frame_raw[i]) send_byte(frame_raw[i], 1'b0);
  endtask

  task automatic run_phase(input int budget, input logic lead_big);
    int          stop;
    int          r;
    frame_kind_e kind;
    stop = bytes_sent + budget;
    if (lead_big) begin
      send_frame(FK_MAX);
      send_frame(FK_OVERFLOW);
    end
    while (bytes_sent < stop) begin
      r = $urandom_range(0, 99);
      if (r < 65)      kind = FK_GOOD;
      else if (r < 75) kind = FK_MISS;
      else if (r < 85) kind = FK_BROKEN;
      else if (r < 95) kind = FK_NOISE;
      else if (r < 98) kind = FK_MAX;
      else             kind = FK_OVERFLOW;
      send_frame(kind);
      if ($urandom_range(0, 9) == 0) gap_calm = ~gap_calm;
      if (owed_results.size() != 0 && $urandom_range(0, 11) == 0) begin
        in_valid_i <= 1'b0;
        while (owed_results.size() != 0) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic [7:0] rand_len();
    return 8'($urandom_range(2, 10));
  endfunction

  function automatic logic [7:0] rand_type();
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic       cfg_open;
    logic [7:0] shared_type;
    logic [7:0] shared_len;
    cfg_open = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int k = 0; k < DIR_N; k++) begin
      if (DIR_ROWS[k].op == ROW_REG) begin
        if (!cfg_open) begin
          settle();
          cfg_open = 1'b1;
        end
        write_reg(DIR_ROWS[k].idx, DIR_ROWS[k].val);
      end else begin
        if (cfg_open) begin
          cfg_we_i <= 1'b0;
          cfg_open = 1'b0;
        end
        send_byte(DIR_ROWS[k].val, DIR_ROWS[k].op == ROW_REJECT);
      end
    end

    program_entries(8'hFF, 8'(FRAME_BYTES), rand_type(), rand_len(), rand_type(), rand_len(),
                    8'h00);
    run_phase(80, 1'b1);

    program_entries(rand_type(), rand_len(), rand_type(), rand_len(), rand_type(), rand_len(),
                    8'h01);
    run_phase(15, 1'b0);

    // entries a and c alike, so c must win; b has zero length
    shared_type = rand_type();
    shared_len  = rand_len();
    program_entries(shared_type, shared_len, 8'h00, 8'h00, shared_type, shared_len, 8'h01);
    run_phase(15, 1'b0);

    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    program_entries(rand_type(), rand_len(), rand_type(), rand_len(), rand_type(), 8'hFF,
                    8'($urandom_range(0, 1)));
    run_phase(15, 1'b0);

    settle();
    if (mismatches == 0 && owed_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ escaped_frame_receiver.f @@
+incdir+rtl
rtl/efr_pkg.sv
rtl/efr_store.sv
rtl/efr_cfg.sv
rtl/escaped_frame_receiver.sv
rtl/efr_checker.sv
verif/escaped_frame_receiver_tb.sv
